/* rtl/fcdb_pkg.sv */
package fcdb_pkg;

    localparam int RATE_W       = 32;
    localparam int INT_BITS     = 20;
    localparam int FRAC_BITS    = 8;
    localparam int DIV_W        = INT_BITS + FRAC_BITS;
    localparam int DIVIDEND_W   = RATE_W + FRAC_BITS;
    localparam int CH_W         = 4;
    localparam int MASK_W       = 10;
    localparam int CFG_IDX_W    = 1;
    localparam int NUM_CHANNELS_DEF = 10;

    localparam logic [DIV_W-1:0]      DIV_ONE   = DIV_W'(1) << FRAC_BITS;
    localparam logic [DIV_W-1:0]      DIV_MAX   = '1;
    localparam logic [DIVIDEND_W-1:0] DIV_ONE_Q = DIVIDEND_W'(DIV_ONE);
    localparam logic [DIVIDEND_W-1:0] DIV_MAX_Q = DIVIDEND_W'(DIV_MAX);

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_REQUEST  = 3'd1,
        MODE_ENABLE   = 3'd2,
        MODE_DISABLE  = 3'd3,
        MODE_SET_RATE = 3'd4,
        MODE_GET_RATE = 3'd5,
        MODE_ROUND    = 3'd6,
        MODE_QUERY    = 3'd7
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARENT_RATE = 1'b0,
        CFG_KEEP_MASK   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEL_REQUEST = 2'd0,
        SEL_STORED  = 2'd1,
        SEL_BEST    = 2'd2
    } div_sel_t;

    typedef struct packed {
        mode_t             mode;
        logic [CH_W-1:0]   channel;
        logic [RATE_W-1:0] rate_request;
    } req_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate_out;
        logic [DIV_W-1:0]  divisor_out;
        logic              enabled;
        logic              bad_channel;
    } rsp_t;

    typedef struct packed {
        logic     capture;
        logic     start_div;
        div_sel_t div_sel;
        logic     take_best;
        logic     commit;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  ch_valid;
        logic  div_done;
    } dp_status_t;

endpackage

/* rtl/fractional_clock_divider_bank_core.sv */
// channel | dir | signals                         | beat taken when
// cfg     | in  | cfg_valid/ready, index, data    | cfg_valid & cfg_ready
// req     | in  | req_valid/ready, req_data       | req_valid & req_ready
// rsp     | out | rsp_valid/ready, rsp_data       | rsp_valid & rsp_ready
//
// One request at a time. Init, request, enable, disable, query and bad channel beats
// skip the divider; get rate and set rate run it once, round rate runs it twice.
// The divider is a 40-step restoring divider, one quotient bit per cycle.
// A new request beat is taken as soon as the previous one is committed to
// the response register, even while that response is stalled.
// Reset: divisors 1.0, enables clear, both config registers zero. cfg always ready.
module fractional_clock_divider_bank_core #(
    parameter int NUM_CHANNELS = fcdb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fcdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcdb_pkg::RATE_W-1:0]    cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fcdb_pkg::req_t                req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fcdb_pkg::rsp_t                rsp_data
);
    import fcdb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fcdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fcdb_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_data  (rsp_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous one still in flight");

    a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_div || status.div_done) |-> !req_ready)
        else $error("divider active while controller idle");

    a_bad_channel_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.bad_channel) |->
            (rsp_data.rate_out == '0 && rsp_data.divisor_out == '0 && !rsp_data.enabled))
        else $error("bad channel response carries data");

    a_commit_gated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid || rsp_ready))
        else $error("response overwritten before taken");

endmodule

/* rtl/fcdb_divider.sv */
module fcdb_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fcdb_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [fcdb_pkg::RATE_W-1:0]     divisor,
    output logic [fcdb_pkg::DIVIDEND_W-1:0] quotient,
    output logic                           done
);
    import fcdb_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [RATE_W-1:0]     rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [RATE_W-1:0]     dsr_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [RATE_W:0]       rem_shift;
    logic [RATE_W:0]       trial;

    // restoring division, one quotient bit per cycle; a zero divisor gives all ones
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = rem_shift - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[RATE_W])
            begin
                rem_next = trial[RATE_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[RATE_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/fcdb_datapath.sv */
module fcdb_datapath #(
    parameter int NUM_CHANNELS = fcdb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [fcdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcdb_pkg::RATE_W-1:0]    cfg_data,
    input  fcdb_pkg::req_t                req_data,
    input  fcdb_pkg::ctrl_cmd_t           cmd,
    output fcdb_pkg::dp_status_t          status,
    output fcdb_pkg::rsp_t                rsp_data
);
    import fcdb_pkg::*;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    req_t                  item_reg;
    logic [RATE_W-1:0]     parent_rate_reg;
    logic [MASK_W-1:0]     keep_mask_reg;
    logic [DIV_W-1:0]      div_store_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] en_reg;
    logic [DIV_W-1:0]      best_reg;
    rsp_t                  rsp_reg, rsp_next;

    logic [NUM_CHANNELS-1:0] mask_bank;
    logic [CH_IDX_W-1:0]   ch_idx;
    logic                  ch_valid;
    logic                  kept;
    logic [DIV_W-1:0]      cur_div;
    logic                  cur_en;
    logic [DIVIDEND_W-1:0] dividend;
    logic [RATE_W-1:0]     operand;
    logic [DIVIDEND_W-1:0] quotient;
    logic                  div_done;
    logic [DIV_W-1:0]      best_next;

    assign mask_bank = NUM_CHANNELS'(keep_mask_reg);
    assign ch_idx    = CH_IDX_W'(item_reg.channel);
    assign ch_valid  = 32'(item_reg.channel) < 32'(NUM_CHANNELS);
    assign kept      = mask_bank[ch_idx];
    assign cur_div   = div_store_reg[ch_idx];
    assign cur_en    = en_reg[ch_idx];
    assign dividend  = DIVIDEND_W'(parent_rate_reg) << FRAC_BITS;

    always_comb
    begin
        unique case (cmd.div_sel)
            SEL_REQUEST: operand = item_reg.rate_request;
            SEL_STORED:  operand = RATE_W'(cur_div);
            SEL_BEST:    operand = RATE_W'(best_reg);
            default:     operand = item_reg.rate_request;
        endcase
    end

    fcdb_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (dividend),
        .divisor  (operand),
        .quotient (quotient),
        .done     (div_done)
    );

    // clamp to [1.0, max divisor]
    always_comb
    begin
        if (quotient < DIV_ONE_Q)
        begin
            best_next = DIV_ONE;
        end
        else if (quotient > DIV_MAX_Q)
        begin
            best_next = DIV_MAX;
        end
        else
        begin
            best_next = quotient[DIV_W-1:0];
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (item_reg.mode == MODE_INIT)
        begin
            if (ch_valid)
            begin
                rsp_next.divisor_out = DIV_ONE;
                rsp_next.enabled     = kept;
            end
        end
        else if (!ch_valid)
        begin
            rsp_next.bad_channel = 1'b1;
        end
        else
        begin
            rsp_next.divisor_out = cur_div;
            rsp_next.enabled     = cur_en;
            case (item_reg.mode) inside
                MODE_REQUEST, MODE_ENABLE:
                begin
                    rsp_next.enabled = 1'b1;
                end
                MODE_DISABLE:
                begin
                    rsp_next.enabled = cur_en & kept;
                end
                MODE_SET_RATE:
                begin
                    rsp_next.divisor_out = best_reg;
                end
                MODE_GET_RATE:
                begin
                    rsp_next.rate_out = quotient[RATE_W-1:0];
                end
                MODE_ROUND:
                begin
                    rsp_next.rate_out    = quotient[RATE_W-1:0];
                    rsp_next.divisor_out = best_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parent_rate_reg <= '0;
            keep_mask_reg   <= '0;
            en_reg          <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                div_store_reg[i] <= DIV_ONE;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PARENT_RATE: parent_rate_reg <= cfg_data;
                    CFG_KEEP_MASK:   keep_mask_reg   <= cfg_data[MASK_W-1:0];
                    default:         parent_rate_reg <= parent_rate_reg;
                endcase
            end
            if (cmd.commit)
            begin
                if (item_reg.mode == MODE_INIT)
                begin
                    en_reg <= mask_bank;
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        div_store_reg[i] <= DIV_ONE;
                    end
                end
                else if (ch_valid)
                begin
                    case (item_reg.mode) inside
                        MODE_REQUEST, MODE_ENABLE:
                        begin
                            en_reg[ch_idx] <= 1'b1;
                        end
                        MODE_DISABLE:
                        begin
                            en_reg[ch_idx] <= cur_en & kept;
                        end
                        MODE_SET_RATE:
                        begin
                            div_store_reg[ch_idx] <= best_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_data;
        end
        if (cmd.take_best)
        begin
            best_reg <= best_next;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.mode     = item_reg.mode;
    assign status.ch_valid = ch_valid;
    assign status.div_done = div_done;
    assign rsp_data        = rsp_reg;

endmodule

/* rtl/fcdb_ctrl.sv */
module fcdb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  fcdb_pkg::dp_status_t status,
    output fcdb_pkg::ctrl_cmd_t  cmd
);
    import fcdb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_DIV1   = 6'b000100,
        S_MID    = 6'b001000,
        S_DIV2   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.div_sel    = SEL_REQUEST;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!status.ch_valid)
                begin
                    state_next = S_FINISH;
                end
                else if (status.mode == MODE_GET_RATE)
                begin
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = SEL_STORED;
                    state_next    = S_DIV2;
                end
                else if (status.mode == MODE_SET_RATE || status.mode == MODE_ROUND)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV1:
            begin
                if (status.div_done)
                begin
                    cmd.take_best = 1'b1;
                    state_next    = S_MID;
                end
            end
            S_MID:
            begin
                if (status.mode == MODE_ROUND)
                begin
                    // second pass: rate the clamped divisor gives
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = SEL_BEST;
                    state_next    = S_DIV2;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV2:
            begin
                if (status.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import fcdb_pkg::*;

    localparam int NUM_CH      = NUM_CHANNELS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 105;
    localparam int NUM_PHASES  = 6;

    localparam rsp_t R_ZERO    = '{32'd0, '0, 1'b0, 1'b0};
    localparam rsp_t R_BAD     = '{32'd0, '0, 1'b0, 1'b1};
    localparam rsp_t R_ONE_OFF = '{32'd0, DIV_ONE, 1'b0, 1'b0};
    localparam rsp_t R_ONE_ON  = '{32'd0, DIV_ONE, 1'b1, 1'b0};
    localparam rsp_t R_MAX_OFF = '{32'd0, DIV_MAX, 1'b0, 1'b0};
    localparam rsp_t R_FULL    = '{32'hFFFF_FFFF, DIV_ONE, 1'b0, 1'b0};

    typedef struct {
        logic        cfg;   // row writes both registers instead of sending a beat
        mode_t       mode;
        logic [3:0]  ch;
        logic [31:0] val;   // rate request, or parent rate on a register row
        logic [9:0]  mask;
        logic        fixed;
        rsp_t        want;
    } dir_row_t;

    dir_row_t dir_tab [25] = '{
        '{1'b0, MODE_QUERY,    4'd0,  32'd0,          10'h000, 1'b1, R_ONE_OFF},
        '{1'b0, MODE_GET_RATE, 4'd3,  32'd0,          10'h000, 1'b1, R_ONE_OFF},
        '{1'b0, MODE_SET_RATE, 4'd15, 32'hFFFF_FFFF,  10'h000, 1'b1, R_BAD},
        '{1'b0, MODE_INIT,     4'd12, 32'd0,          10'h000, 1'b1, R_ZERO},
        '{1'b1, MODE_INIT,     4'd0,  32'hFFFF_FFFF,  10'h201, 1'b0, R_ZERO},
        '{1'b0, MODE_INIT,     4'd0,  32'd0,          10'h000, 1'b1, R_ONE_ON},
        '{1'b0, MODE_INIT,     4'd9,  32'd0,          10'h000, 1'b1, R_ONE_ON},
        '{1'b0, MODE_DISABLE,  4'd0,  32'd0,          10'h000, 1'b1, R_ONE_ON},
        '{1'b0, MODE_REQUEST,  4'd1,  32'd0,          10'h000, 1'b1, R_ONE_ON},
        '{1'b0, MODE_ENABLE,   4'd1,  32'd0,          10'h000, 1'b1, R_ONE_ON},
        '{1'b0, MODE_DISABLE,  4'd1,  32'd0,          10'h000, 1'b1, R_ONE_OFF},
        '{1'b0, MODE_SET_RATE, 4'd2,  32'd0,          10'h000, 1'b1, R_MAX_OFF},
        '{1'b0, MODE_GET_RATE, 4'd2,  32'd0,          10'h000, 1'b0, R_ZERO},
        '{1'b0, MODE_SET_RATE, 4'd3,  32'hFFFF_FFFF,  10'h000, 1'b1, R_ONE_OFF},
        '{1'b0, MODE_SET_RATE, 4'd4,  32'd1,          10'h000, 1'b1, R_MAX_OFF},
        '{1'b0, MODE_ROUND,    4'd5,  32'd0,          10'h000, 1'b0, R_ZERO},
        '{1'b0, MODE_ROUND,    4'd5,  32'hFFFF_FFFF,  10'h000, 1'b1, R_FULL},
        '{1'b0, MODE_ROUND,    4'd5,  32'd12_345_678, 10'h000, 1'b0, R_ZERO},
        '{1'b0, MODE_GET_RATE, 4'd3,  32'd0,          10'h000, 1'b1, R_FULL},
        '{1'b0, MODE_QUERY,    4'd10, 32'd0,          10'h000, 1'b1, R_BAD},
        '{1'b0, MODE_GET_RATE, 4'd15, 32'd0,          10'h000, 1'b1, R_BAD},
        '{1'b0, MODE_INIT,     4'd15, 32'd0,          10'h000, 1'b1, R_ZERO},
        '{1'b0, MODE_SET_RATE, 4'd7,  32'h8000_0000,  10'h000, 1'b0, R_ZERO},
        '{1'b0, MODE_QUERY,    4'd9,  32'd0,          10'h000, 1'b1, R_ONE_ON},
        '{1'b0, MODE_DISABLE,  4'd9,  32'd0,          10'h000, 1'b1, R_ONE_ON}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req_data;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp_data;

    // typed expectation traveling alongside the request beat
    logic dir_fixed;
    rsp_t dir_want;

    // divider bank mirror
    logic [RATE_W-1:0] parent_hz = '0;
    logic [MASK_W-1:0] keep_mask = '0;
    logic [DIV_W-1:0]  div_table [NUM_CH];
    logic              en_table  [NUM_CH];

    rsp_t rsp_due [$];
    int   n_taken = 0;
    int   n_seen = 0;
    int   quiet_cycles = 0;
    int   errors = 0;
    bit   tx_burst = 1'b0;

    fractional_clock_divider_bank_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [DIV_W-1:0] pick_divisor(logic [RATE_W-1:0] want_hz);
        logic [DIVIDEND_W-1:0] q;
        if (want_hz == '0)
            return DIV_MAX;
        q = {parent_hz, {FRAC_BITS{1'b0}}} / DIVIDEND_W'(want_hz);
        if (q < DIV_ONE_Q)
            q = DIV_ONE_Q;
        if (q > DIV_MAX_Q)
            q = DIV_MAX_Q;
        return q[DIV_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] rate_for(logic [DIV_W-1:0] dv);
        logic [DIVIDEND_W-1:0] q;
        q = {parent_hz, {FRAC_BITS{1'b0}}} / DIVIDEND_W'(dv);
        return q[RATE_W-1:0];
    endfunction

    function automatic rsp_t bank_step(req_t r);
        rsp_t             o;
        logic [DIV_W-1:0] dv;
        o = '0;
        if (r.mode == MODE_INIT)
        begin
            // whole bank is reset whatever the channel says
            for (int i = 0; i < NUM_CH; i++)
            begin
                div_table[i] = DIV_ONE;
                en_table[i]  = keep_mask[i];
            end
            if (r.channel < NUM_CH)
            begin
                o.divisor_out = div_table[r.channel];
                o.enabled     = en_table[r.channel];
            end
            return o;
        end
        if (r.channel >= NUM_CH)
        begin
            o.bad_channel = 1'b1;
            return o;
        end
        dv = div_table[r.channel];
        case (r.mode)
            MODE_REQUEST, MODE_ENABLE:
                en_table[r.channel] = 1'b1;
            MODE_DISABLE:
                if (!keep_mask[r.channel])
                    en_table[r.channel] = 1'b0;
            MODE_SET_RATE:
            begin
                dv = pick_divisor(r.rate_request);
                div_table[r.channel] = dv;
            end
            MODE_GET_RATE:
                o.rate_out = rate_for(dv);
            MODE_ROUND:
            begin
                dv = pick_divisor(r.rate_request);
                o.rate_out = rate_for(dv);
            end
            default: ;
        endcase
        o.divisor_out = dv;
        o.enabled     = en_table[r.channel];
        return o;
    endfunction

    task automatic report(string what, rsp_t want, rsp_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: exp rate=%h div=%h en=%b bad=%b  got rate=%h div=%h en=%b bad=%b",
                     $realtime, what, want.rate_out, want.divisor_out, want.enabled,
                     want.bad_channel, got.rate_out, got.divisor_out, got.enabled,
                     got.bad_channel);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            div_table[i] = DIV_ONE;
            en_table[i]  = 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        logic beat;
        if (rst_n)
        begin
            beat = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                beat = 1'b1;
                if (cfg_index == CFG_PARENT_RATE)
                    parent_hz = cfg_data;
                else
                    keep_mask = cfg_data[MASK_W-1:0];
            end
            if (req_valid && req_ready)
            begin
                beat = 1'b1;
                want = bank_step(req_data);
                rsp_due.push_back(dir_fixed ? dir_want : want);
                n_taken <= n_taken + 1;
            end
            if (rsp_valid && rsp_ready)
            begin
                beat = 1'b1;
                if (rsp_due.size() == 0)
                    report("unexpected beat", R_ZERO, rsp_data);
                else
                begin
                    want = rsp_due.pop_front();
                    n_seen <= n_seen + 1;
                    if (rsp_data.rate_out !== want.rate_out ||
                        rsp_data.divisor_out !== want.divisor_out ||
                        rsp_data.enabled !== want.enabled ||
                        rsp_data.bad_channel !== want.bad_channel)
                        report("mismatch", want, rsp_data);
                end
            end
            quiet_cycles <= beat ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // response side: random stalls, burst stretches, and one long hold-off
    initial
    begin : rsp_sink
        int unsigned w;
        int          beats;
        bit          rx_burst;
        beats    = 0;
        rx_burst = 1'b0;
        rsp_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_burst = !rx_burst;
            w = rx_burst ? 0 : $urandom_range(0, 17);
            if (beats == 300)
                w = 400;
            if (w != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
            beats++;
        end
    end

    task automatic offer(req_t r, logic fixed, rsp_t want);
        int unsigned w;
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        w = tx_burst ? 0 : $urandom_range(0, 17);
        if (w != 0)
        begin
            req_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        req_data  <= r;
        dir_fixed <= fixed;
        dir_want  <= want;
        req_valid <= 1'b1;
        do @(posedge clk); while (!(req_valid && req_ready));
    endtask

    task automatic quiesce();
        req_valid <= 1'b0;
        do @(posedge clk); while (n_taken != n_seen);
    endtask

    task automatic write_regs(logic [RATE_W-1:0] parent, logic [MASK_W-1:0] mask);
        cfg_index <= CFG_PARENT_RATE;
        cfg_data  <= parent;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_index <= CFG_KEEP_MASK;
        cfg_data  <= RATE_W'(mask);
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        req_t              r;
        int unsigned       k;
        logic [RATE_W-1:0] parent_cur;
        logic [MASK_W-1:0] mask_cur;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PARENT_RATE;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req_data  <= '0;
        dir_fixed <= 1'b0;
        dir_want  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].cfg)
            begin
                quiesce();
                write_regs(dir_tab[i].val, dir_tab[i].mask);
            end
            else
            begin
                r.mode         = dir_tab[i].mode;
                r.channel      = dir_tab[i].ch;
                r.rate_request = dir_tab[i].val;
                offer(r, dir_tab[i].fixed, dir_tab[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    parent_cur = '0;
                    mask_cur   = '0;
                end
                1:
                begin
                    parent_cur = '1;
                    mask_cur   = '1;
                end
                2:
                begin
                    parent_cur = $urandom_range(1, 1000);
                    mask_cur   = MASK_W'($urandom_range(0, 1023));
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       parent_cur = $urandom;
                        1:       parent_cur = $urandom_range(1_000_000, 1_000_000_000);
                        default: parent_cur = $urandom_range(1, 65535);
                    endcase
                    mask_cur = MASK_W'($urandom_range(0, 1023));
                end
            endcase
            quiesce();
            write_regs(parent_cur, mask_cur);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // init wipes the bank, keep it rare so state builds up
                if ($urandom_range(0, 99) < 3)
                    r.mode = MODE_INIT;
                else
                    r.mode = mode_t'($urandom_range(1, 7));
                if ($urandom_range(0, 99) < 88)
                    r.channel = CH_W'($urandom_range(0, NUM_CH - 1));
                else
                    r.channel = CH_W'($urandom_range(NUM_CH, 15));
                k = $urandom_range(0, 19);
                if (k == 0)
                    r.rate_request = '0;
                else if (k == 1)
                    r.rate_request = '1;
                else if (k <= 3)
                    r.rate_request = $urandom_range(1, 255);
                else if (k <= 10)
                    r.rate_request = parent_cur / $urandom_range(1, 5000) + $urandom_range(0, 3);
                else
                    r.rate_request = $urandom;
                offer(r, 1'b0, R_ZERO);
            end
        end

        quiesce();
        repeat (100) @(posedge clk);
        if (errors == 0 && rsp_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
